// ===== rtl/core/gbmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbmf_pkg
// Shared types, constants and lookup functions of the binary message framer.
// ----------------------------------------------------------------------------
package gbmf_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] SYNC_BYTE = 8'h40;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;

    // Header "@@", two identifier bytes, checksum, CR and LF.
    localparam logic [8:0] MIN_FRAME_LEN = 9'd7;

    typedef enum logic [2:0] {
        PH_SYNC1    = 3'd0,
        PH_SYNC2    = 3'd1,
        PH_ID1      = 3'd2,
        PH_ID2      = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_CHECKSUM = 3'd5,
        PH_CR       = 3'd6,
        PH_LF       = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_HB   = 3'd1,
        KIND_HN   = 3'd2,
        KIND_HA   = 3'd3,
        KIND_BB   = 3'd4,
        KIND_AS   = 3'd5,
        KIND_CJ   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CSUM    = 2'd1,
        ST_TRAILER = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] frame_type;
        logic [7:0] payload_byte;
        logic [8:0] payload_index;
        logic       end_of_frame;
        logic [1:0] frame_status;
    } result_t;

    function automatic kind_t id_lookup(input logic [7:0] first, input logic [7:0] second);
        kind_t kind;
        kind = KIND_NONE;
        priority if (first == 8'h48 && second == 8'h62) kind = KIND_HB;
        else if (first == 8'h48 && second == 8'h6E) kind = KIND_HN;
        else if (first == 8'h48 && second == 8'h61) kind = KIND_HA;
        else if (first == 8'h42 && second == 8'h62) kind = KIND_BB;
        else if (first == 8'h41 && second == 8'h73) kind = KIND_AS;
        else if (first == 8'h43 && second == 8'h6A) kind = KIND_CJ;
        else kind = KIND_NONE;
        return kind;
    endfunction

    // Payload length: full frame length minus the seven framing bytes.
    function automatic logic [8:0] payload_len(input kind_t kind);
        logic [8:0] len;
        unique case (kind)
            KIND_HB: len = 9'd54 - MIN_FRAME_LEN;
            KIND_HN: len = 9'd78 - MIN_FRAME_LEN;
            KIND_HA: len = 9'd154 - MIN_FRAME_LEN;
            KIND_BB: len = 9'd92 - MIN_FRAME_LEN;
            KIND_AS: len = 9'd20 - MIN_FRAME_LEN;
            KIND_CJ: len = 9'd294 - MIN_FRAME_LEN;
            default: len = 9'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gps_binary_message_framer_top.sv =====
`default_nettype none
// m_valid for a payload byte or the LF byte rises once its record has passed
// through the result queue and then the output register.
// Throughput: one byte per cycle; s_ready drops only while the result queue is
// full, which happens when the result side stalls.
// Reset: synchronous, active low; the parser returns to hunting for the first
// sync byte and the queue and output register are emptied.
// ----------------------------------------------------------------------------
// gps_binary_message_framer_top
// Frames binary messages with XOR checksum from a received byte stream.
// ----------------------------------------------------------------------------
module gps_binary_message_framer_top
    import gbmf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_frame_type,
    output logic [7:0]      m_payload_byte,
    output logic [8:0]      m_payload_index,
    output logic            m_end_of_frame,
    output logic [1:0]      m_frame_status
);

    logic    byte_accept;
    logic    push;
    result_t push_data;
    logic    q_pop;
    result_t q_data;
    logic    q_empty;
    logic    q_full;
    result_t m_data;

    assign s_ready     = !q_full;
    assign byte_accept = s_valid && s_ready;

    gbmf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .push        (push),
        .push_data   (push_data)
    );

    gbmf_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    gbmf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_frame_type    = m_data.frame_type;
    assign m_payload_byte  = m_data.payload_byte;
    assign m_payload_index = m_data.payload_index;
    assign m_end_of_frame  = m_data.end_of_frame;
    assign m_frame_status  = m_data.frame_status;

endmodule
`default_nettype wire

// ===== rtl/core/gbmf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbmf_front
// Byte parser: hunts for sync, classifies the identifier, tracks the payload
// and checksum, and emits one result record per payload byte or frame end.
// ----------------------------------------------------------------------------
module gbmf_front
    import gbmf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_accept,
    input  wire logic [7:0] rx_byte,
    output logic            push,
    output result_t         push_data
);

    phase_t     phase_reg, phase_next;
    logic [7:0] first_id_reg, first_id_next;
    kind_t      kind_reg, kind_next;
    logic [8:0] plen_reg, plen_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] xor_reg, xor_next;

    kind_t      id_kind;
    logic [8:0] pos_inc;

    assign id_kind = id_lookup(first_id_reg, rx_byte);
    assign pos_inc = pos_reg + 9'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC1;
            first_id_reg <= 8'd0;
            kind_reg     <= KIND_NONE;
            plen_reg     <= 9'd0;
            pos_reg      <= 9'd0;
            xor_reg      <= 8'd0;
        end else begin
            phase_reg    <= phase_next;
            first_id_reg <= first_id_next;
            kind_reg     <= kind_next;
            plen_reg     <= plen_next;
            pos_reg      <= pos_next;
            xor_reg      <= xor_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        first_id_next = first_id_reg;
        kind_next     = kind_reg;
        plen_next     = plen_reg;
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        push          = 1'b0;
        push_data     = '{frame_type: kind_reg, payload_byte: rx_byte,
                          payload_index: pos_reg, end_of_frame: 1'b0,
                          frame_status: ST_GOOD};
        if (byte_accept) begin
            unique case (phase_reg)
                PH_SYNC1: begin
                    if (rx_byte == SYNC_BYTE) phase_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_ID1 : PH_SYNC1;
                end
                PH_ID1: begin
                    // Extra sync bytes keep the framer waiting for the identifier.
                    if (rx_byte != SYNC_BYTE) begin
                        first_id_next = rx_byte;
                        phase_next    = PH_ID2;
                    end
                end
                PH_ID2: begin
                    if (id_kind != KIND_NONE) begin
                        kind_next  = id_kind;
                        plen_next  = payload_len(id_kind);
                        pos_next   = 9'd0;
                        xor_next   = first_id_reg ^ rx_byte;
                        phase_next = PH_PAYLOAD;
                    end else begin
                        plen_next  = 9'd0;
                        pos_next   = 9'd0;
                        phase_next = PH_SYNC1;
                    end
                end
                PH_PAYLOAD: begin
                    push     = 1'b1;
                    xor_next = xor_reg ^ rx_byte;
                    pos_next = pos_inc;
                    if (pos_inc >= plen_reg) phase_next = PH_CHECKSUM;
                end
                PH_CHECKSUM: begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_CR;
                end
                PH_CR: begin
                    // The position counter is reused as the bad-CR flag.
                    pos_next   = (rx_byte == CR_BYTE) ? 9'd0 : 9'd1;
                    phase_next = PH_LF;
                end
                PH_LF: begin
                    push = 1'b1;
                    push_data.payload_byte  = 8'd0;
                    push_data.payload_index = plen_reg;
                    push_data.end_of_frame  = 1'b1;
                    priority if (xor_reg != 8'd0) push_data.frame_status = ST_CSUM;
                    else if (pos_reg != 9'd0 || rx_byte != LF_BYTE)
                        push_data.frame_status = ST_TRAILER;
                    else push_data.frame_status = ST_GOOD;
                    plen_next  = 9'd0;
                    pos_next   = 9'd0;
                    phase_next = PH_SYNC1;
                end
                default: phase_next = PH_SYNC1;
            endcase
        end
    end

    a_push_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (phase_reg == PH_PAYLOAD || phase_reg == PH_LF))
        else $error("result record produced outside payload or LF phase");

    a_payload_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (pos_reg < plen_reg))
        else $error("payload position ran past the payload length");

    a_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD || phase_reg == PH_LF) |-> (kind_reg != KIND_NONE))
        else $error("frame in progress without a known type");

endmodule
`default_nettype wire

// ===== rtl/core/gbmf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbmf_queue
// Short first-in first-out queue of result records between parser and output.
// ----------------------------------------------------------------------------
module gbmf_queue
    import gbmf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output result_t      pop_data,
    output logic         empty,
    output logic         full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    result_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == DEPTH_CNT);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("read from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/gbmf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbmf_back
// Output stage: pulls records from the queue into the result register.
// ----------------------------------------------------------------------------
module gbmf_back
    import gbmf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_empty,
    input  wire result_t q_data,
    output logic         q_pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    logic    valid_reg;
    result_t data_reg;

    // Refill whenever the register is free or its record is leaving this cycle.
    assign q_pop   = !q_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) data_reg <= q_data;
    end

endmodule
`default_nettype wire
